// ===== rtl/sfc_pkg.sv =====
package sfc_pkg;

   // Default size of the pinned digest in bytes.
   localparam int DIGEST_BYTES_DEF = 32;

   // Number of characters in the "SHA256:" prefix.
   localparam int PREFIX_CHARS = 7;

   // Item kinds, shared by the request and the response channels.
   localparam logic KIND_TEXT   = 1'b0;
   localparam logic KIND_DIGEST = 1'b1;

   // One request item.
   typedef struct packed {
      logic       kind;
      logic [7:0] char_or_byte;
      logic       last;
   } sfc_req_type;

   // One response item.
   typedef struct packed {
      logic report_kind;
      logic ok;
   } sfc_rsp_type;

   // Per-item control handed from the accept stage to the compare stage.
   typedef struct packed {
      logic       kind;
      logic       last;
      logic [7:0] data;
      logic       compare;
      logic       ok;
   } sfc_stage_type;

   // Expected character at each prefix position.
   function automatic logic [7:0] prefix_char(input logic [2:0] pos);
      logic [7:0] c;
      case (pos)
         3'd0:    c = 8'h53;   // S
         3'd1:    c = 8'h48;   // H
         3'd2:    c = 8'h41;   // A
         3'd3:    c = 8'h32;   // 2
         3'd4:    c = 8'h35;   // 5
         3'd5:    c = 8'h36;   // 6
         default: c = 8'h3A;   // colon
      endcase
      return c;
   endfunction

   // Base64 decode: bit 6 is set for a legal character, bits 5:0 hold its value.
   function automatic logic [6:0] b64_decode(input logic [7:0] c);
      logic [6:0] r;
      r = 7'd0;
      if (c >= 8'h41 && c <= 8'h5A) begin
         r = {1'b1, 6'(c - 8'h41)};
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         r = {1'b1, 6'(c - 8'h61 + 8'd26)};
      end else if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 6'(c - 8'h30 + 8'd52)};
      end else if (c == 8'h2B) begin
         r = {1'b1, 6'd62};
      end else if (c == 8'h2F) begin
         r = {1'b1, 6'd63};
      end
      return r;
   endfunction

   // Mask with the low cnt bits set, over the 12-bit accumulator.
   function automatic logic [11:0] low_mask(input logic [3:0] cnt);
      return (12'd1 << cnt) - 12'd1;
   endfunction

endpackage

// ===== rtl/sfc_ram.sv =====
module sfc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/sfc_text_decode.sv =====
module sfc_text_decode #(
   parameter int DIGEST_BYTES = sfc_pkg::DIGEST_BYTES_DEF,
   localparam int ADDR_W = (DIGEST_BYTES > 1) ? $clog2(DIGEST_BYTES) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              take,
   input  logic [7:0]        char_in,
   input  logic              last,
   output logic              wr_en,
   output logic [ADDR_W-1:0] wr_addr,
   output logic [7:0]        wr_data,
   output logic              verdict,
   output logic              pin_valid
);

   import sfc_pkg::*;

   localparam int B64_CHARS  = (DIGEST_BYTES * 4 + 2) / 3;
   localparam int TEXT_CHARS = PREFIX_CHARS + B64_CHARS;
   localparam int POS_W      = $clog2(TEXT_CHARS + 2);
   localparam int IDX_W      = POS_W + 2;

   logic [POS_W-1:0] pos_ff, pos_in;
   logic             bad_ff, bad_in;
   logic [11:0]      acc_ff, acc_in;
   logic [3:0]       cnt_ff, cnt_in;
   logic             pin_ff, pin_in;

   logic [6:0]       dec;
   logic [POS_W-1:0] k;
   logic [IDX_W-1:0] n;
   logic [IDX_W-1:0] idx;
   logic [11:0]      acc_t;
   logic [3:0]       cnt_t;
   logic             bad_t;
   logic [POS_W-1:0] pos_t;

   // Byte index completed by base64 character k: ((k + 1) * 6 / 8) - 1.
   assign k   = pos_ff - POS_W'(PREFIX_CHARS);
   assign n   = {2'b00, k} + {1'b0, k, 1'b0} + IDX_W'(3);
   assign idx = (n >> 2) - IDX_W'(1);
   assign dec = b64_decode(char_in);

   // Check one character, shift its six bits in and emit a completed byte.
   always_comb begin
      pos_in  = pos_ff;
      bad_in  = bad_ff;
      acc_in  = acc_ff;
      cnt_in  = cnt_ff;
      pin_in  = pin_ff;
      wr_en   = 1'b0;
      wr_addr = idx[ADDR_W-1:0];
      wr_data = 8'd0;
      verdict = 1'b0;
      acc_t   = acc_ff;
      cnt_t   = cnt_ff;
      bad_t   = bad_ff;
      pos_t   = pos_ff;
      if (take) begin
         if (pos_ff == '0) begin
            pin_in = 1'b0;
         end
         if (pos_ff < POS_W'(PREFIX_CHARS)) begin
            if (char_in != prefix_char(pos_ff[2:0])) begin
               bad_t = 1'b1;
            end
         end else if (pos_ff < POS_W'(TEXT_CHARS)) begin
            if (!dec[6]) begin
               bad_t = 1'b1;
            end else begin
               acc_t = {acc_ff[5:0], dec[5:0]};
               cnt_t = cnt_ff + 4'd6;
               if (cnt_t >= 4'd8) begin
                  wr_data = 8'(acc_t >> (cnt_t - 4'd8));
                  cnt_t   = cnt_t - 4'd8;
                  acc_t   = acc_t & low_mask(cnt_t);
                  wr_en   = (idx < IDX_W'(DIGEST_BYTES));
               end
            end
         end else begin
            bad_t = 1'b1;
         end
         if (pos_ff < POS_W'(TEXT_CHARS + 1)) begin
            pos_t = pos_ff + POS_W'(1);
         end
         if (last) begin
            // End of run: the leftover bits must be zero for a canonical text.
            verdict = !bad_t && (pos_t == POS_W'(TEXT_CHARS))
                      && ((acc_t & low_mask(cnt_t)) == 12'd0);
            pin_in  = verdict;
            pos_in  = '0;
            bad_in  = 1'b0;
            acc_in  = 12'd0;
            cnt_in  = 4'd0;
         end else begin
            pos_in = pos_t;
            bad_in = bad_t;
            acc_in = acc_t;
            cnt_in = cnt_t;
         end
      end
   end

   // Text run state and the pin flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         bad_ff <= 1'b0;
         acc_ff <= 12'd0;
         cnt_ff <= 4'd0;
         pin_ff <= 1'b0;
      end else begin
         pos_ff <= pos_in;
         bad_ff <= bad_in;
         acc_ff <= acc_in;
         cnt_ff <= cnt_in;
         pin_ff <= pin_in;
      end
   end

   assign pin_valid = pin_ff;

endmodule

// ===== rtl/sfc_compare_out.sv =====
module sfc_compare_out (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  sfc_pkg::sfc_stage_type stage_in,
   input  logic [7:0]            rd_data,
   input  logic                  rsp_stall,
   output logic                  hold,
   output logic                  rsp_valid,
   output sfc_pkg::sfc_rsp_type  rsp_data
);

   import sfc_pkg::*;

   logic          s1_valid_ff, s1_valid_in;
   sfc_stage_type s1_ff, s1_in;
   logic [7:0]    diff_ff, diff_in;
   logic          rsp_valid_ff, rsp_valid_in;
   sfc_rsp_type   rsp_data_ff, rsp_data_in;

   logic          out_free;
   logic          s1_move;
   logic [7:0]    diff_acc;
   logic          ok;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign s1_move  = s1_valid_ff && out_free;
   assign hold     = s1_valid_ff && !out_free;

   // Fold this byte's difference into the run and form the verdict.
   always_comb begin
      diff_acc = diff_ff | (s1_ff.compare ? (rd_data ^ s1_ff.data) : 8'd0);
      if (s1_ff.kind == KIND_DIGEST) begin
         ok = s1_ff.ok && (diff_acc == 8'd0);
      end else begin
         ok = s1_ff.ok;
      end
   end

   // Stage and output register updates.
   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_in        = s1_ff;
      diff_in      = diff_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (s1_move) begin
         s1_valid_in = 1'b0;
         if (s1_ff.kind == KIND_DIGEST) begin
            diff_in = s1_ff.last ? 8'd0 : diff_acc;
         end
         if (s1_ff.last) begin
            rsp_valid_in            = 1'b1;
            rsp_data_in.report_kind = s1_ff.kind;
            rsp_data_in.ok          = ok;
         end
      end
      if (load) begin
         s1_valid_in = 1'b1;
         s1_in       = stage_in;
      end
   end

   // Control state is reset; payloads are not.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         diff_ff      <= 8'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         diff_ff      <= diff_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      s1_ff       <= s1_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== rtl/sha256_fingerprint_check.sv =====
// Channel   Direction  Handshake            Payload
// req_      in         req_valid/req_stall  sfc_req_type (kind, char_or_byte, last)
// rsp_      out        rsp_valid/rsp_stall  sfc_rsp_type (report_kind, ok)
//
// One item is accepted per cycle while req_stall is low; the result of the item
// with last set passes the compare stage and then the result register.
// Reset is synchronous and clears all run state and the pin; the digest
// memory is not cleared, and is only trusted once a canonical text run passes.
// While a result waits under rsp_stall, one more item can wait in the compare
// stage; req_stall then stays high until the waiting result is taken.
module sha256_fingerprint_check #(
   parameter int DIGEST_BYTES = sfc_pkg::DIGEST_BYTES_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  sfc_pkg::sfc_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output sfc_pkg::sfc_rsp_type rsp_data
);

   import sfc_pkg::*;

   localparam int ADDR_W = (DIGEST_BYTES > 1) ? $clog2(DIGEST_BYTES) : 1;
   localparam int DPOS_W = $clog2(DIGEST_BYTES + 2);

   logic              accept;
   logic              take_text;
   logic              take_digest;
   logic              hold;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [7:0]        wr_data;
   logic              verdict;
   logic              pin_valid;
   logic [7:0]        rd_data;

   logic [DPOS_W-1:0] dpos_ff, dpos_in;
   logic [DPOS_W-1:0] dpos_t;
   logic              in_range;
   logic              len_ok;
   sfc_stage_type     stage;

   assign req_stall   = hold;
   assign accept      = req_valid && !hold;
   assign take_text   = accept && (req_data.kind == KIND_TEXT);
   assign take_digest = accept && (req_data.kind == KIND_DIGEST);

   // Fingerprint text decoding and pin state.
   sfc_text_decode #(
      .DIGEST_BYTES (DIGEST_BYTES)
   ) u_text (
      .clock     (clock),
      .reset     (reset),
      .take      (take_text),
      .char_in   (req_data.char_or_byte),
      .last      (req_data.last),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .verdict   (verdict),
      .pin_valid (pin_valid)
   );

   // Digest byte position, saturating one past the digest length.
   always_comb begin
      in_range = (dpos_ff < DPOS_W'(DIGEST_BYTES));
      dpos_t   = dpos_ff;
      if (dpos_ff < DPOS_W'(DIGEST_BYTES + 1)) begin
         dpos_t = dpos_ff + DPOS_W'(1);
      end
      len_ok  = (dpos_t == DPOS_W'(DIGEST_BYTES));
      dpos_in = dpos_ff;
      if (take_digest) begin
         dpos_in = req_data.last ? '0 : dpos_t;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dpos_ff <= '0;
      end else begin
         dpos_ff <= dpos_in;
      end
   end

   // Expected digest store.
   sfc_ram #(
      .WIDTH (8),
      .DEPTH (DIGEST_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (take_digest && in_range),
      .rd_addr (dpos_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   // Control passed along with the item to the compare stage.
   always_comb begin
      stage.kind    = req_data.kind;
      stage.last    = req_data.last;
      stage.data    = req_data.char_or_byte;
      stage.compare = (req_data.kind == KIND_DIGEST) && in_range;
      stage.ok      = (req_data.kind == KIND_TEXT) ? verdict : (pin_valid && len_ok);
   end

   // Difference accumulation and result register.
   sfc_compare_out u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (accept),
      .stage_in  (stage),
      .rd_data   (rd_data),
      .rsp_stall (rsp_stall),
      .hold      (hold),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== tb/sv/sha256_fingerprint_check_test.sv =====
`timescale 1ns / 1ps

module sha256_fingerprint_check_test;
   import sfc_pkg::*;

   localparam int DIGEST_BYTES   = DIGEST_BYTES_DEF;
   localparam int B64_CHARS      = (DIGEST_BYTES * 4 + 2) / 3;
   localparam int TEXT_CHARS     = PREFIX_CHARS + B64_CHARS;
   localparam int ENC_BITS       = 6 * B64_CHARS;
   localparam int PAD_BITS       = ENC_BITS - 8 * DIGEST_BYTES;
   localparam int RANDOM_ITEMS   = 960;
   localparam int HOLD_CYCLES    = 300;
   localparam int SETTLE_CYCLES  = 8;
   localparam int WATCHDOG_LIMIT = 2000;

   // Shapes of one run of items, text or digest.
   typedef enum logic [3:0] {
      TXT_CANON, TXT_SHORT, TXT_LONG, TXT_BAD_PREFIX, TXT_BAD_CHAR, TXT_LEFTOVER,
      TXT_SPLIT, TXT_NOISE, DG_MATCH, DG_FLIP, DG_SHORT, DG_LONG, DG_NOISE
   } run_shape_type;

   // How the pinned digest is chosen before a run is built.
   typedef enum logic [1:0] {PIN_KEEP, PIN_ZERO, PIN_ONES, PIN_RANDOM} pin_pick_type;

   typedef struct packed {
      run_shape_type shape;
      pin_pick_type  pin;
      logic          typed;
      logic          ok;
   } step_row_type;

   typedef logic [7:0] byte_q_type [$];

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   sfc_req_type req_data  = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   sfc_rsp_type rsp_data;

   string pin_prefix   = "SHA256:";
   string b64_alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   // Directed runs; a verdict is typed in only where it is obvious.
   step_row_type directed_rows [17] = '{
      '{TXT_SHORT,      PIN_ZERO,   1'b1, 1'b0},
      '{TXT_CANON,      PIN_ZERO,   1'b1, 1'b1},
      '{DG_MATCH,       PIN_KEEP,   1'b1, 1'b1},
      '{DG_FLIP,        PIN_KEEP,   1'b1, 1'b0},
      '{TXT_CANON,      PIN_ONES,   1'b1, 1'b1},
      '{DG_MATCH,       PIN_KEEP,   1'b1, 1'b1},
      '{DG_SHORT,       PIN_KEEP,   1'b1, 1'b0},
      '{DG_LONG,        PIN_KEEP,   1'b1, 1'b0},
      '{TXT_LEFTOVER,   PIN_KEEP,   1'b1, 1'b0},
      '{DG_MATCH,       PIN_KEEP,   1'b1, 1'b0},
      '{TXT_BAD_PREFIX, PIN_KEEP,   1'b1, 1'b0},
      '{TXT_BAD_CHAR,   PIN_KEEP,   1'b1, 1'b0},
      '{TXT_LONG,       PIN_KEEP,   1'b1, 1'b0},
      '{TXT_CANON,      PIN_RANDOM, 1'b0, 1'b0},
      '{DG_MATCH,       PIN_KEEP,   1'b0, 1'b0},
      '{TXT_SPLIT,      PIN_KEEP,   1'b0, 1'b0},
      '{DG_NOISE,       PIN_KEEP,   1'b0, 1'b0}
   };

   // Predicted state of the checker.
   int          text_pos  = 0;
   bit          text_bad  = 1'b0;
   logic [11:0] bit_acc   = '0;
   int          bit_cnt   = 0;
   logic [7:0]  pin_store [DIGEST_BYTES];
   bit          pin_ok    = 1'b0;
   int          digest_pos = 0;
   logic [7:0]  digest_diff = '0;

   sfc_rsp_type expected_verdicts [$];
   sfc_req_type run_items [$];
   logic [7:0]  tb_pin [DIGEST_BYTES];

   int send_idle_pct = 0;
   int rcv_idle_pct  = 0;
   bit hold_request  = 1'b0;
   int items_sent    = 0;
   int fail_count    = 0;
   int idle_cycles   = 0;

   sha256_fingerprint_check #(
      .DIGEST_BYTES(DIGEST_BYTES)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #10 clock = ~clock;

   // Base64 value of a character, or -1 when it is outside the alphabet.
   function automatic int b64_value(input logic [7:0] c);
      if (c >= "A" && c <= "Z") return int'(c) - int'(8'h41);
      if (c >= "a" && c <= "z") return int'(c) - int'(8'h61) + 26;
      if (c >= "0" && c <= "9") return int'(c) - int'(8'h30) + 52;
      if (c == "+") return 62;
      if (c == "/") return 63;
      return -1;
   endfunction

   // Advances the predicted state by one item; returns 1 when a verdict is due.
   function automatic bit predict_verdict(input sfc_req_type item, output sfc_rsp_type verdict);
      int v;
      int k;
      int idx;
      bit ok;
      verdict = '0;
      if (item.kind == KIND_TEXT) begin
         if (text_pos == 0) pin_ok = 1'b0;
         if (text_pos < PREFIX_CHARS) begin
            if (item.char_or_byte != pin_prefix[text_pos]) text_bad = 1'b1;
         end else if (text_pos < TEXT_CHARS) begin
            v = b64_value(item.char_or_byte);
            if (v < 0) begin
               text_bad = 1'b1;
            end else begin
               k = text_pos - PREFIX_CHARS;
               bit_acc = {bit_acc[5:0], 6'(v)};
               bit_cnt = bit_cnt + 6;
               // A whole byte is complete: store it and keep the leftover bits.
               if (bit_cnt >= 8) begin
                  idx = ((k * 6 + 6) >> 3) - 1;
                  bit_cnt = bit_cnt - 8;
                  if (idx < DIGEST_BYTES) pin_store[idx] = 8'(bit_acc >> bit_cnt);
                  bit_acc = bit_acc & ((12'd1 << bit_cnt) - 12'd1);
               end
            end
         end else begin
            text_bad = 1'b1;
         end
         if (text_pos < TEXT_CHARS + 1) text_pos++;
         if (!item.last) return 1'b0;
         ok = !text_bad && text_pos == TEXT_CHARS &&
              ((bit_acc & ((12'd1 << bit_cnt) - 12'd1)) == 12'd0);
         pin_ok   = ok;
         text_pos = 0;
         text_bad = 1'b0;
         bit_acc  = '0;
         bit_cnt  = 0;
         verdict.report_kind = KIND_TEXT;
         verdict.ok          = ok;
         return 1'b1;
      end
      // Digest bytes past the pinned length are counted but not compared.
      if (digest_pos < DIGEST_BYTES) digest_diff |= pin_store[digest_pos] ^ item.char_or_byte;
      if (digest_pos < DIGEST_BYTES + 1) digest_pos++;
      if (!item.last) return 1'b0;
      verdict.report_kind = KIND_DIGEST;
      verdict.ok          = pin_ok && digest_pos == DIGEST_BYTES && digest_diff == 8'd0;
      digest_pos  = 0;
      digest_diff = '0;
      return 1'b1;
   endfunction

   // Canonical fingerprint text of the current pin.
   function automatic byte_q_type encode_pin();
      byte_q_type chars;
      logic [ENC_BITS-1:0] bits;
      int i;
      bits = '0;
      for (i = 0; i < DIGEST_BYTES; i++) bits[ENC_BITS-1-8*i -: 8] = tb_pin[i];
      for (i = 0; i < PREFIX_CHARS; i++) chars.push_back(pin_prefix[i]);
      for (i = 0; i < B64_CHARS; i++) chars.push_back(b64_alphabet[bits[ENC_BITS-1-6*i -: 6]]);
      return chars;
   endfunction

   function automatic logic [7:0] random_non_b64();
      logic [7:0] c;
      do c = 8'($urandom_range(255)); while (b64_value(c) >= 0);
      return c;
   endfunction

   task automatic pick_pin(input pin_pick_type pick);
      int i;
      for (i = 0; i < DIGEST_BYTES; i++) begin
         case (pick)
            PIN_ZERO:   tb_pin[i] = 8'h00;
            PIN_ONES:   tb_pin[i] = 8'hFF;
            PIN_RANDOM: tb_pin[i] = 8'($urandom_range(255));
            default: begin
            end
         endcase
      end
   endtask

   task automatic add_item(input logic kind, input logic [7:0] data, input logic last);
      sfc_req_type item;
      item.kind         = kind;
      item.char_or_byte = data;
      item.last         = last;
      run_items.push_back(item);
   endtask

   // Fills run_items with one run of the given shape.
   task automatic build_run(input run_shape_type shape);
      byte_q_type chars;
      int i;
      int j;
      int n;
      int pos;
      run_items.delete();
      if (shape <= TXT_NOISE) begin
         chars = encode_pin();
         case (shape)
            TXT_SHORT: begin
               n = ($urandom_range(3) == 0) ? 1 : $urandom_range(1, TEXT_CHARS - 1);
               while (chars.size() > n) void'(chars.pop_back());
            end
            TXT_LONG: begin
               repeat ($urandom_range(1, 12)) chars.push_back(b64_alphabet[$urandom_range(63)]);
            end
            TXT_BAD_PREFIX: begin
               pos = $urandom_range(PREFIX_CHARS - 1);
               chars[pos] = chars[pos] ^ 8'($urandom_range(1, 255));
            end
            TXT_BAD_CHAR: begin
               chars[$urandom_range(PREFIX_CHARS, TEXT_CHARS - 1)] = random_non_b64();
            end
            TXT_LEFTOVER: begin
               n = b64_value(chars[TEXT_CHARS-1]) | $urandom_range(1, (1 << PAD_BITS) - 1);
               chars[TEXT_CHARS-1] = b64_alphabet[n];
            end
            TXT_NOISE: begin
               // Plausible and random characters in equal share, to give runs a chance to get past the prefix.
               chars.delete();
               n = $urandom_range(1, 60);
               for (pos = 0; pos < n; pos++) begin
                  case ($urandom_range(3))
                     0: chars.push_back(pos < PREFIX_CHARS ? pin_prefix[pos]
                                                           : b64_alphabet[$urandom_range(63)]);
                     1: chars.push_back(b64_alphabet[$urandom_range(63)]);
                     default: chars.push_back(8'($urandom_range(255)));
                  endcase
               end
            end
            default: begin
            end
         endcase
         for (i = 0; i < chars.size(); i++) begin
            // Short digest runs dropped between characters of the text.
            if (shape == TXT_SPLIT && i > 0 && i < chars.size() - 1 &&
                $urandom_range(15) == 0) begin
               n = $urandom_range(1, 3);
               for (j = 0; j < n; j++) add_item(KIND_DIGEST, 8'($urandom_range(255)), j == n - 1);
            end
            add_item(KIND_TEXT, chars[i], i == chars.size() - 1);
         end
      end else begin
         for (i = 0; i < DIGEST_BYTES; i++) chars.push_back(tb_pin[i]);
         case (shape)
            DG_FLIP: begin
               pos = $urandom_range(DIGEST_BYTES - 1);
               if ($urandom_range(1) == 0) chars[pos] = chars[pos] ^ (8'd1 << $urandom_range(7));
               else chars[pos] = chars[pos] ^ 8'($urandom_range(1, 255));
            end
            DG_SHORT: begin
               n = $urandom_range(1, DIGEST_BYTES - 1);
               while (chars.size() > n) void'(chars.pop_back());
            end
            DG_LONG: begin
               repeat ($urandom_range(1, 8)) chars.push_back(8'($urandom_range(255)));
            end
            DG_NOISE: begin
               chars.delete();
               repeat ($urandom_range(1, 40)) chars.push_back(8'($urandom_range(255)));
            end
            default: begin
            end
         endcase
         for (i = 0; i < chars.size(); i++) add_item(KIND_DIGEST, chars[i], i == chars.size() - 1);
      end
   endtask

   // Offers one item, waits for it to be taken and records its verdict.
   task automatic drive_item(input sfc_req_type item, input bit typed, input bit typed_ok);
      sfc_rsp_type verdict;
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
      if (predict_verdict(item, verdict)) begin
         if (typed) verdict.ok = typed_ok;
         expected_verdicts.push_back(verdict);
      end
   endtask

   task automatic send_run(input bit typed, input bit typed_ok);
      int i;
      for (i = 0; i < run_items.size(); i++)
         drive_item(run_items[i], typed && i == run_items.size() - 1, typed_ok);
   endtask

   // Mostly well-formed pins followed by digests, with malformed runs mixed in.
   task automatic random_run();
      int r;
      r = $urandom_range(99);
      if (r < 20) begin
         pick_pin(PIN_RANDOM);
         build_run(TXT_CANON);
      end else if (r < 62) begin
         build_run(DG_MATCH);
      end else if (r < 72) begin
         build_run(DG_FLIP);
      end else if (r < 77) begin
         build_run(DG_SHORT);
      end else if (r < 81) begin
         build_run(DG_LONG);
      end else if (r < 89) begin
         case ($urandom_range(4))
            0: build_run(TXT_SHORT);
            1: build_run(TXT_LONG);
            2: build_run(TXT_BAD_PREFIX);
            3: build_run(TXT_BAD_CHAR);
            default: build_run(TXT_LEFTOVER);
         endcase
      end else if (r < 94) begin
         build_run(TXT_SPLIT);
      end else if (r < 97) begin
         build_run(TXT_NOISE);
      end else begin
         build_run(DG_NOISE);
      end
      send_run(1'b0, 1'b0);
   endtask

   // Receiver: random stalls, or one long hold-off when asked for.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_stall <= ($urandom_range(99) < rcv_idle_pct);
         end
      end
   end

   // Compare each accepted result with the oldest expected verdict.
   always @(posedge clock) begin : result_check
      sfc_rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (expected_verdicts.size() == 0) begin
            $error("unexpected result: report_kind %0d ok %0d", rsp_data.report_kind, rsp_data.ok);
            fail_count++;
         end else begin
            want = expected_verdicts.pop_front();
            if (rsp_data.report_kind !== want.report_kind) begin
               $error("report_kind: expected %0d, actual %0d", want.report_kind,
                      rsp_data.report_kind);
               fail_count++;
            end
            if (rsp_data.ok !== want.ok) begin
               $error("ok: expected %0d, actual %0d", want.ok, rsp_data.ok);
               fail_count++;
            end
         end
      end
   end

   // Count cycles in which neither channel moves an item.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid === 1'b1 && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      @(posedge clock);
      while (idle_cycles < WATCHDOG_LIMIT) @(posedge clock);
      $display("status: fail");
      $finish;
   end

   // Main sequence: reset, directed runs, then three random phases.
   initial begin
      int n;
      int phase;
      int phase_end;
      bit hold_done;
      int send_pcts [3];
      int rcv_pcts [3];
      send_pcts = '{19, 66, 0};
      rcv_pcts  = '{66, 19, 0};
      hold_done = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      send_idle_pct = send_pcts[0];
      rcv_idle_pct  = rcv_pcts[0];
      for (n = 0; n < $size(directed_rows); n++) begin
         pick_pin(directed_rows[n].pin);
         build_run(directed_rows[n].shape);
         send_run(directed_rows[n].typed, directed_rows[n].ok);
      end
      for (phase = 0; phase < 3; phase++) begin
         send_idle_pct = send_pcts[phase];
         rcv_idle_pct  = rcv_pcts[phase];
         phase_end = items_sent + RANDOM_ITEMS / 3;
         while (items_sent < phase_end) begin
            // Halfway through the last phase the receiver holds off for a while.
            if (phase == 2 && !hold_done && items_sent >= phase_end - RANDOM_ITEMS / 6) begin
               hold_request = 1'b1;
               hold_done    = 1'b1;
            end
            random_run();
         end
      end
      req_valid <= 1'b0;
      while (expected_verdicts.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_verdicts.size() != 0) begin
         $error("%0d expected verdicts never arrived", expected_verdicts.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
